@@ hdl/cbom_pkg.sv @@
`default_nettype none

package cbom_pkg;

    // Width of the millisecond time counter and of the deadline.
    localparam int TIME_BITS = 17;
    localparam int CALC_BITS = 33;

    localparam logic [CALC_BITS-1:0] TIME_MAX_CALC =
        CALC_BITS'((CALC_BITS'(1) << TIME_BITS) - CALC_BITS'(1));
    localparam logic [TIME_BITS-1:0] TIME_MAX = TIME_MAX_CALC[TIME_BITS-1:0];

    // Word patterns seen on the command line.
    localparam logic [7:0]  RESPONSE_TOP_BYTE = 8'h3F;
    localparam logic [31:0] START_PREV_WORD   = 32'h5100_0000;
    localparam logic [31:0] START_WORD        = 32'h0000_1351;
    localparam logic [31:0] FAIL_WORD         = 32'h0000_142F;
    localparam logic [31:0] SUCCESS_PREV_WORD = 32'h40AA_5458;
    localparam logic [31:0] SUCCESS_WORD      = 32'h0000_BA3B;

    // Word counter after the start mark.
    localparam logic [3:0] WORD_COUNT_MAX     = 4'd15;
    localparam logic [3:0] WORD_COUNT_RESTORE = 4'd10;

    // Register reset values.
    localparam logic [15:0] DETECT_TIMEOUT_RESET = 16'd20;
    localparam logic [15:0] TOTAL_TIMEOUT_RESET  = 16'd300;
    localparam logic [15:0] AFTER_TIMEOUT_RESET  = 16'd6;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_WORD  = 2'd1,
        CMD_TICK  = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        OUT_MISSING = 2'd0,
        OUT_TIMEOUT = 2'd1,
        OUT_FAILURE = 2'd2,
        OUT_SUCCESS = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        REG_DETECT = 2'd0,
        REG_TOTAL  = 2'd1,
        REG_AFTER  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [15:0] detect_timeout_ms;
        logic [15:0] total_timeout_ms;
        logic [15:0] after_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] outcome;
        logic       response_seen;
    } t_result;

    // Saturate a wide time value to the counter range.
    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [CALC_BITS-1:0] v);
        logic [TIME_BITS-1:0] r;
        if (v > TIME_MAX_CALC) begin
            r = TIME_MAX;
        end else begin
            r = v[TIME_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/command_bus_outcome_monitor_unit.sv @@
`default_nettype none

// Command bus outcome monitor.
// The input channel (i_in_valid / o_in_ready) carries one item per transfer:
// i_command 0 starts an attempt, 1 delivers a sniffed command word on i_word,
// 2 is a one-millisecond tick; command 3 is ignored. The output channel
// (o_out_valid / i_out_ready) carries one transfer when an attempt ends, with
// o_outcome (missing, timeout, failure, success) and o_response_seen.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the detect,
// total and after timeouts at indexes 0, 1 and 2; it is always ready.
// An item is held in the input register, where the classifier step runs, and
// its result enters the output register, which drives o_out_valid. One item
// is taken per cycle unless its result finds the output stage full.
// Reset (synchronous, active low) restores the register defaults 20, 300, 6
// and leaves the block idle until a start item. When the receiver stalls the
// result is held; items that produce no result keep flowing, and an item that
// ends an attempt waits in the input register until the output stage frees.

module command_bus_outcome_monitor_unit
    import cbom_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [1:0] i_command,
    input  wire [31:0] i_word,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [1:0] o_outcome,
    output logic       o_response_seen,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [1:0] i_cfg_index,
    input  wire [15:0] i_cfg_data
);

    t_cfg    cfg;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    cbom_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cbom_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_word      (i_word),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    cbom_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_outcome       = out_res.outcome;
    assign o_response_seen = out_res.response_seen;

endmodule

`default_nettype wire

@@ hdl/cbom_cfg_regs.sv @@
`default_nettype none

module cbom_cfg_regs
    import cbom_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [1:0] i_cfg_index,
    input  wire [15:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // Writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_timeout_ms <= DETECT_TIMEOUT_RESET;
            r_cfg.total_timeout_ms  <= TOTAL_TIMEOUT_RESET;
            r_cfg.after_timeout_ms  <= AFTER_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DETECT: r_cfg.detect_timeout_ms <= i_cfg_data;
                REG_TOTAL:  r_cfg.total_timeout_ms  <= i_cfg_data;
                REG_AFTER:  r_cfg.after_timeout_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbom_core.sv @@
`default_nettype none

module cbom_core
    import cbom_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire   [1:0] i_command,
    input  wire  [31:0] i_word,
    output logic        o_res_valid,
    input  wire         i_res_ready,
    output t_result     o_res
);

    // Input register.
    logic        r_in_valid;
    logic  [1:0] r_in_command;
    logic [31:0] r_in_word;

    // Attempt state.
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic [31:0]          r_prev, n_prev;
    logic                 r_card, n_card;
    logic                 r_started, n_started;
    logic [3:0]           r_count, n_count;
    logic                 r_active, n_active;

    logic    fire;
    t_result res;
    logic    advance;

    // The held item moves on unless its result finds the output stage full.
    assign advance     = r_in_valid && (!fire || i_res_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_res_valid = r_in_valid && fire;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_command <= i_command;
            r_in_word    <= i_word;
        end
    end

    // One step of the attempt classifier on the held item.
    always_comb begin
        n_elapsed  = r_elapsed;
        n_deadline = r_deadline;
        n_prev     = r_prev;
        n_card     = r_card;
        n_started  = r_started;
        n_count    = r_count;
        n_active   = r_active;
        fire       = 1'b0;
        res        = '0;
        case (r_in_command)
            CMD_START: begin
                n_elapsed  = '0;
                n_deadline = clamp_time(CALC_BITS'(i_cfg.detect_timeout_ms));
                n_prev     = '0;
                n_card     = 1'b0;
                n_started  = 1'b0;
                n_count    = '0;
                n_active   = 1'b1;
            end
            CMD_TICK: begin
                if (r_active) begin
                    if (r_elapsed != TIME_MAX) begin
                        n_elapsed = r_elapsed + TIME_BITS'(1);
                    end
                    if (n_elapsed >= r_deadline) begin
                        n_active          = 1'b0;
                        fire              = 1'b1;
                        res.outcome       = r_started ? OUT_TIMEOUT : OUT_MISSING;
                        res.response_seen = r_card;
                    end
                end
            end
            CMD_WORD: begin
                if (r_active) begin
                    // First card response moves the deadline to the total limit.
                    if (!r_card && r_in_word[31:24] == RESPONSE_TOP_BYTE) begin
                        n_deadline = clamp_time(CALC_BITS'(i_cfg.total_timeout_ms));
                        n_card     = 1'b1;
                    end
                    if (r_started && r_count < WORD_COUNT_MAX) begin
                        n_count = r_count + 4'd1;
                    end
                    // Start mark; only the first one sets the short deadline.
                    if (r_prev == START_PREV_WORD && r_in_word == START_WORD) begin
                        if (!r_started) begin
                            n_deadline = clamp_time(CALC_BITS'(r_elapsed)
                                + CALC_BITS'(i_cfg.after_timeout_ms));
                        end
                        n_started = 1'b1;
                    end
                    if (r_prev == START_PREV_WORD && r_in_word == FAIL_WORD) begin
                        n_active          = 1'b0;
                        fire              = 1'b1;
                        res.outcome       = OUT_FAILURE;
                        res.response_seen = n_card;
                    end else if (r_prev == SUCCESS_PREV_WORD && r_in_word == SUCCESS_WORD) begin
                        n_active          = 1'b0;
                        fire              = 1'b1;
                        res.outcome       = OUT_SUCCESS;
                        res.response_seen = n_card;
                    end else begin
                        if (n_count == WORD_COUNT_RESTORE) begin
                            n_deadline = clamp_time(CALC_BITS'(i_cfg.total_timeout_ms));
                        end
                        n_prev = r_in_word;
                    end
                end
            end
            default: ;
        endcase
    end

    // Commit the step when the item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_deadline <= '0;
            r_prev     <= '0;
            r_card     <= 1'b0;
            r_started  <= 1'b0;
            r_count    <= '0;
            r_active   <= 1'b0;
        end else if (advance) begin
            r_elapsed  <= n_elapsed;
            r_deadline <= n_deadline;
            r_prev     <= n_prev;
            r_card     <= n_card;
            r_started  <= n_started;
            r_count    <= n_count;
            r_active   <= n_active;
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbom_out_reg.sv @@
`default_nettype none

module cbom_out_reg
    import cbom_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_res_valid,
    output logic         o_res_ready,
    input  wire t_result i_res,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // A new result may enter as the held one is taken.
    assign o_res_ready = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire
